// ===== rtl/bfb_pkg.sv =====
`timescale 1ns / 1ps

package bfb_pkg;

   // fixed field widths of the channels
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 7;
   localparam int COUNT_W  = 9;
   localparam int LANE_MAX = 8;

   typedef logic [BYTE_W-1:0] byte_type;

   // request action codes
   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_READ  = 2'd1,
      ACT_PEEK  = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   // control states of the top level
   typedef enum logic {
      ST_IDLE,
      ST_STREAM
   } state_type;

endpackage

// ===== rtl/bfb_req_if.sv =====
`timescale 1ns / 1ps

interface bfb_req_if;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 action;
   logic [bfb_pkg::LEN_W-1:0]  length;
   bfb_pkg::byte_type          byte_0;
   bfb_pkg::byte_type          byte_1;
   bfb_pkg::byte_type          byte_2;
   bfb_pkg::byte_type          byte_3;
   bfb_pkg::byte_type          byte_4;
   bfb_pkg::byte_type          byte_5;
   bfb_pkg::byte_type          byte_6;
   bfb_pkg::byte_type          byte_7;

   modport source (
      output valid, action, length,
      output byte_0, byte_1, byte_2, byte_3, byte_4, byte_5, byte_6, byte_7,
      input  ready
   );

   modport sink (
      input  valid, action, length,
      input  byte_0, byte_1, byte_2, byte_3, byte_4, byte_5, byte_6, byte_7,
      output ready
   );
endinterface

// ===== rtl/bfb_rsp_if.sv =====
`timescale 1ns / 1ps

interface bfb_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         status;
   logic [bfb_pkg::LEN_W-1:0]    moved;
   bfb_pkg::byte_type            read_byte;
   logic [bfb_pkg::COUNT_W-1:0]  used_count;
   logic [bfb_pkg::COUNT_W-1:0]  free_count;
   logic                         last;

   modport source (
      output valid, status, moved, read_byte, used_count, free_count, last,
      input  ready
   );

   modport sink (
      input  valid, status, moved, read_byte, used_count, free_count, last,
      output ready
   );
endinterface

// ===== rtl/bfb_lane.sv =====
`timescale 1ns / 1ps

module bfb_lane #(
   parameter int LANES = 8,
   parameter int ROWS  = 32,
   parameter int BANK  = 0,
   localparam int BW   = (LANES > 1) ? $clog2(LANES) : 1,
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [BW-1:0]                     wr_bank,
   input  logic [RW-1:0]                     wr_row,
   input  logic [BW:0]                       wr_len,
   input  logic [LANES-1:0][bfb_pkg::BYTE_W-1:0] wr_bytes,
   input  logic                              rd_en,
   input  logic [BW-1:0]                     rd_bank,
   input  logic [RW-1:0]                     rd_row,
   output bfb_pkg::byte_type                 rd_data
);

   localparam logic [BW:0]   BANK_C    = (BW+1)'(BANK);
   localparam logic [BW:0]   LANES_C   = (BW+1)'(LANES);
   localparam logic [BW-1:0] BANK_B    = BW'(BANK);
   localparam logic [RW-1:0] ROWS_LAST = RW'(ROWS - 1);

   bfb_pkg::byte_type mem [ROWS];
   bfb_pkg::byte_type rd_data_ff;

   logic [BW:0]   offset;
   logic [RW-1:0] row;
   logic          we;

   // which byte of the burst lands in this bank, and on which row
   always_comb begin
      if (BANK_C >= {1'b0, wr_bank}) begin
         offset = BANK_C - {1'b0, wr_bank};
         row    = wr_row;
      end else begin
         offset = BANK_C + LANES_C - {1'b0, wr_bank};
         row    = (wr_row == ROWS_LAST) ? '0 : wr_row + RW'(1);
      end
      we = wr_en && (offset < wr_len);
   end

   // bank storage, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem[row] <= wr_bytes[offset[BW-1:0]];
      end
      if (rd_en && (rd_bank == BANK_B)) begin
         rd_data_ff <= mem[rd_row];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bfb_merge.sv =====
`timescale 1ns / 1ps

module bfb_merge #(
   parameter int LANES = 8,
   localparam int BW   = (LANES > 1) ? $clog2(LANES) : 1
) (
   input  logic                                  clock,
   input  logic                                  rd_en,
   input  logic [BW-1:0]                         rd_bank,
   input  logic [LANES-1:0][bfb_pkg::BYTE_W-1:0] lane_data,
   output bfb_pkg::byte_type                     rd_byte
);

   logic [BW-1:0] sel_ff;

   // remember which bank was read, its data shows up in the next cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         sel_ff <= rd_bank;
      end
   end

   // pick the byte of the bank that was read
   assign rd_byte = lane_data[sel_ff];

endmodule

// ===== rtl/byte_fifo_burst.sv =====
`timescale 1ns / 1ps

// byte_fifo_burst: circular byte fifo with all-or-nothing bursts
// req_chan (valid/ready) carries an action, a length and up to eight write
// bytes; rsp_chan (valid/ready) returns one item per result.
// write: up to WRITE_LANES bytes stored together, one result item that
//    is registered and shows the cycle after acceptance.
// clear, rejected or zero-length requests: one result item, shown the same way.
// read / peek of n bytes: each byte passes the single registered read port
//    of its bank memory and the merge into the output register, then one
//    byte per cycle follows while rsp_ready is high.
//    req_ready stays low until the last byte of the burst is loaded.
// storage is split into WRITE_LANES banks of ceil(DEPTH / WRITE_LANES) rows,
// so a whole write burst goes to distinct banks at once; bank reads are
// merged into one byte stream.
// every result carries the used and free counts after the whole request.
// reset: pointers and the fill count go to zero, the fifo is empty; the
// storage itself is not cleared and needs no clearing pass.
// a stalled receiver holds the output register; a new request is taken
// only in the cycle the previous result is taken or the register is empty.

module byte_fifo_burst #(
   parameter int DEPTH       = 256,
   parameter int MAX_BURST   = 64,
   parameter int WRITE_LANES = 8
) (
   input  logic          clock,
   input  logic          reset,
   bfb_req_if.sink       req_chan,
   bfb_rsp_if.source     rsp_chan
);

   localparam int ROWS = (DEPTH + WRITE_LANES - 1) / WRITE_LANES;
   localparam int BW   = (WRITE_LANES > 1) ? $clog2(WRITE_LANES) : 1;
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int FW   = $clog2(DEPTH + 1);
   localparam int CW   = ((FW > bfb_pkg::LEN_W) ? FW : bfb_pkg::LEN_W) + 1;
   localparam int LW   = bfb_pkg::LEN_W;

   localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
   localparam logic [CW-1:0] BURST_C   = CW'(MAX_BURST);
   localparam logic [CW-1:0] LANES_CW  = CW'(WRITE_LANES);
   localparam logic [BW:0]   LANES_C   = (BW+1)'(WRITE_LANES);
   localparam logic [BW-1:0] BANK_LAST = BW'(WRITE_LANES - 1);
   localparam logic [RW-1:0] ROWS_LAST = RW'(ROWS - 1);

   // control state
   bfb_pkg::state_type state_ff, state_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [BW-1:0] wb_ff, wb_in, rb_ff, rb_in, sb_ff, sb_in;
   logic [RW-1:0] wr_ff, wr_in, rr_ff, rr_in, sr_ff, sr_in;
   logic [LW-1:0] issue_left_ff, issue_left_in;
   logic [LW-1:0] emit_left_ff, emit_left_in;
   logic          consume_ff, consume_in;
   logic          pend_ff, pend_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // result payload
   logic                         status_ff, status_in;
   logic [LW-1:0]                moved_ff, moved_in;
   bfb_pkg::byte_type            byte_ff, byte_in;
   logic [bfb_pkg::COUNT_W-1:0]  used_ff, used_in;
   logic [bfb_pkg::COUNT_W-1:0]  free_ff, free_in;
   logic                         last_ff, last_in;

   // datapath wiring
   bfb_pkg::action_type act;
   logic [LW-1:0]       req_len;
   logic [CW-1:0]       len_x;
   logic [CW-1:0]       space;
   logic                wr_rej, rd_rej;
   logic                acc, rsp_free, load, issue, load_rsp;
   logic                lane_wr_en;
   logic [BW:0]         lane_wr_len;
   logic [BW:0]         wb_sum;
   logic [bfb_pkg::LANE_MAX-1:0][bfb_pkg::BYTE_W-1:0] all_bytes;
   logic [WRITE_LANES-1:0][bfb_pkg::BYTE_W-1:0]       lane_bytes;
   logic [WRITE_LANES-1:0][bfb_pkg::BYTE_W-1:0]       lane_data;
   bfb_pkg::byte_type   merge_byte;

   function automatic logic [RW-1:0] row_inc(input logic [RW-1:0] r);
      return (r == ROWS_LAST) ? '0 : r + RW'(1);
   endfunction

   // handshake and request decode
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == bfb_pkg::ST_IDLE) && rsp_free;
   assign acc      = req_chan.valid && req_chan.ready;
   assign act      = bfb_pkg::action_type'(req_chan.action);
   assign req_len  = req_chan.length;
   assign len_x    = CW'(req_len);
   assign space    = DEPTH_C - CW'(fill_ff);
   assign wr_rej   = (len_x > LANES_CW) || (len_x > space);
   assign rd_rej   = (len_x > BURST_C) || (len_x > CW'(fill_ff));
   assign load     = pend_ff && rsp_free;
   assign issue    = (state_ff == bfb_pkg::ST_STREAM) && (issue_left_ff != '0)
                     && (!pend_ff || load);
   assign wb_sum   = {1'b0, wb_ff} + (BW+1)'(req_len);

   assign all_bytes = {req_chan.byte_7, req_chan.byte_6, req_chan.byte_5,
                       req_chan.byte_4, req_chan.byte_3, req_chan.byte_2,
                       req_chan.byte_1, req_chan.byte_0};
   assign lane_bytes = all_bytes[WRITE_LANES-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bfb_pkg::ST_IDLE: begin
            if (acc && (act == bfb_pkg::ACT_READ || act == bfb_pkg::ACT_PEEK)
                && !rd_rej && (req_len != '0)) begin
               state_in = bfb_pkg::ST_STREAM;
            end
         end
         bfb_pkg::ST_STREAM: begin
            if (load && (emit_left_ff == LW'(1))) begin
               state_in = bfb_pkg::ST_IDLE;
            end
         end
         default: state_in = state_ff;
      endcase
   end

   // pointers, counts and result register
   always_comb begin
      fill_in       = fill_ff;
      wb_in         = wb_ff;
      wr_in         = wr_ff;
      rb_in         = rb_ff;
      rr_in         = rr_ff;
      sb_in         = sb_ff;
      sr_in         = sr_ff;
      issue_left_in = issue_left_ff;
      emit_left_in  = emit_left_ff;
      consume_in    = consume_ff;
      status_in     = status_ff;
      moved_in      = moved_ff;
      byte_in       = byte_ff;
      used_in       = used_ff;
      free_in       = free_ff;
      last_in       = last_ff;
      lane_wr_en    = 1'b0;
      lane_wr_len   = '0;
      load_rsp      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;

      // new request, single results go straight to the output register
      if (acc) begin
         load_rsp  = 1'b1;
         status_in = 1'b0;
         moved_in  = '0;
         byte_in   = '0;
         last_in   = 1'b1;
         case (act)
            bfb_pkg::ACT_CLEAR: begin
               fill_in = '0;
               wb_in   = '0;
               wr_in   = '0;
               rb_in   = '0;
               rr_in   = '0;
            end
            bfb_pkg::ACT_WRITE: begin
               if (wr_rej) begin
                  status_in = 1'b1;
               end else begin
                  lane_wr_en  = 1'b1;
                  lane_wr_len = (BW+1)'(req_len);
                  fill_in     = fill_ff + FW'(req_len);
                  moved_in    = req_len;
                  if (wb_sum >= LANES_C) begin
                     wb_in = BW'(wb_sum - LANES_C);
                     wr_in = row_inc(wr_ff);
                  end else begin
                     wb_in = BW'(wb_sum);
                  end
               end
            end
            default: begin
               if (rd_rej) begin
                  status_in = 1'b1;
               end else if (req_len != '0) begin
                  load_rsp      = 1'b0;
                  moved_in      = req_len;
                  issue_left_in = req_len;
                  emit_left_in  = req_len;
                  consume_in    = (act == bfb_pkg::ACT_READ);
                  sb_in         = rb_ff;
                  sr_in         = rr_ff;
                  if (act == bfb_pkg::ACT_READ) begin
                     fill_in = fill_ff - FW'(req_len);
                  end
               end
            end
         endcase
      end

      // stream read: step through the banks one byte a cycle, holding while a pending byte waits
      if (issue) begin
         issue_left_in = issue_left_ff - LW'(1);
         if (sb_ff == BANK_LAST) begin
            sb_in = '0;
            sr_in = row_inc(sr_ff);
         end else begin
            sb_in = sb_ff + BW'(1);
         end
      end

      // stream load: merged byte into the output register
      if (load) begin
         load_rsp     = 1'b1;
         status_in    = 1'b0;
         byte_in      = merge_byte;
         last_in      = (emit_left_ff == LW'(1));
         emit_left_in = emit_left_ff - LW'(1);
         if ((emit_left_ff == LW'(1)) && consume_ff) begin
            rb_in = sb_ff;
            rr_in = sr_ff;
         end
      end

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         used_in      = bfb_pkg::COUNT_W'(fill_in);
         free_in      = bfb_pkg::COUNT_W'(DEPTH_C - CW'(fill_in));
      end
   end

   // pending bank data waits here until the output register takes it
   assign pend_in = issue ? 1'b1 : (load ? 1'b0 : pend_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bfb_pkg::ST_IDLE;
         fill_ff       <= '0;
         wb_ff         <= '0;
         wr_ff         <= '0;
         rb_ff         <= '0;
         rr_ff         <= '0;
         sb_ff         <= '0;
         sr_ff         <= '0;
         issue_left_ff <= '0;
         emit_left_ff  <= '0;
         consume_ff    <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         wb_ff         <= wb_in;
         wr_ff         <= wr_in;
         rb_ff         <= rb_in;
         rr_ff         <= rr_in;
         sb_ff         <= sb_in;
         sr_ff         <= sr_in;
         issue_left_ff <= issue_left_in;
         emit_left_ff  <= emit_left_in;
         consume_ff    <= consume_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      moved_ff  <= moved_in;
      byte_ff   <= byte_in;
      used_ff   <= used_in;
      free_ff   <= free_in;
      last_ff   <= last_in;
   end

   // banked storage
   for (genvar g = 0; g < WRITE_LANES; g++) begin : g_lane
      bfb_lane #(
         .LANES (WRITE_LANES),
         .ROWS  (ROWS),
         .BANK  (g)
      ) u_lane (
         .clock    (clock),
         .wr_en    (lane_wr_en),
         .wr_bank  (wb_ff),
         .wr_row   (wr_ff),
         .wr_len   (lane_wr_len),
         .wr_bytes (lane_bytes),
         .rd_en    (issue),
         .rd_bank  (sb_ff),
         .rd_row   (sr_ff),
         .rd_data  (lane_data[g])
      );
   end

   // bank merge
   bfb_merge #(
      .LANES (WRITE_LANES)
   ) u_merge (
      .clock     (clock),
      .rd_en     (issue),
      .rd_bank   (sb_ff),
      .lane_data (lane_data),
      .rd_byte   (merge_byte)
   );

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = status_ff;
   assign rsp_chan.moved      = moved_ff;
   assign rsp_chan.read_byte  = byte_ff;
   assign rsp_chan.used_count = used_ff;
   assign rsp_chan.free_count = free_ff;
   assign rsp_chan.last       = last_ff;

   // fill count never exceeds the capacity
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      CW'(fill_ff) <= DEPTH_C)
      else $error("fill count above capacity");

   // bytes still to emit are those not yet read plus the one in flight
   a_stream_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bfb_pkg::ST_STREAM) |->
      ((LW+1)'(emit_left_ff) == (LW+1)'(issue_left_ff) + (LW+1)'(pend_ff)))
      else $error("stream byte counts out of step");

   // bank data only pending while streaming
   a_pend_stream: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == bfb_pkg::ST_STREAM))
      else $error("bank data pending outside a stream");

   // the last byte of a burst ends the stream
   a_stream_end: assert property (@(posedge clock) disable iff (reset)
      (load && (emit_left_ff == LW'(1))) |=> (state_ff == bfb_pkg::ST_IDLE))
      else $error("stream did not end after its last byte");

   // only accepted read or peek bursts give results that are not marked last
   a_mid_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !last_ff) |-> (!status_ff && (moved_ff != '0)))
      else $error("non-final result outside an accepted burst");

endmodule

// ===== tb/byte_fifo_burst_test.sv =====
`timescale 1ns / 1ps

module byte_fifo_burst_test;

   localparam int FIFO_DEPTH  = 256;
   localparam int BURST_MAX   = 64;
   localparam int IDLE_LIMIT  = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_ITEMS = 108;

   typedef struct {
      bfb_pkg::action_type                  action;
      logic [bfb_pkg::LEN_W-1:0]            length;
      bfb_pkg::byte_type                    lane [bfb_pkg::LANE_MAX];
   } fifo_request_type;

   typedef struct {
      logic                                 status;
      logic [bfb_pkg::LEN_W-1:0]            moved;
      bfb_pkg::byte_type                    read_byte;
      logic [bfb_pkg::COUNT_W-1:0]          used_count;
      logic [bfb_pkg::COUNT_W-1:0]          free_count;
      logic                                 last;
   } fifo_result_type;

   // mirror of the fifo contents and the results each request must give
   class fifo_mirror;
      bfb_pkg::byte_type  store [FIFO_DEPTH];
      int unsigned        wr_ptr;
      int unsigned        rd_ptr;
      int unsigned        fill;
      fifo_result_type    due_results [$];
      int unsigned        checked;
      int unsigned        errors;

      function new();
         wr_ptr = 0;
         rd_ptr = 0;
         fill = 0;
         checked = 0;
         errors = 0;
      endfunction

      // counts always show the state after the whole request
      function void add_result(logic status, int unsigned moved, bfb_pkg::byte_type rb,
                               logic last);
         fifo_result_type r;
         r.status = status;
         r.moved = moved[bfb_pkg::LEN_W-1:0];
         r.read_byte = rb;
         r.used_count = fill[bfb_pkg::COUNT_W-1:0];
         r.free_count = bfb_pkg::COUNT_W'(FIFO_DEPTH - fill);
         r.last = last;
         due_results.push_back(r);
      endfunction

      function void take_request(fifo_request_type rq);
         int unsigned        n;
         int unsigned        p;
         bfb_pkg::byte_type  burst [$];
         n = 32'(rq.length);
         case (rq.action)
            bfb_pkg::ACT_CLEAR: begin
               wr_ptr = 0;
               rd_ptr = 0;
               fill = 0;
               add_result(1'b0, 0, '0, 1'b1);
            end
            bfb_pkg::ACT_WRITE: begin
               if (n > bfb_pkg::LANE_MAX || n > FIFO_DEPTH - fill) begin
                  add_result(1'b1, 0, '0, 1'b1);
               end else begin
                  for (int i = 0; i < n; i++) begin
                     store[wr_ptr] = rq.lane[i];
                     wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
                  end
                  fill += n;
                  add_result(1'b0, n, '0, 1'b1);
               end
            end
            default: begin
               // read or peek: all or nothing, bounded by the stored count and BURST_MAX
               if (n > BURST_MAX || n > fill) begin
                  add_result(1'b1, 0, '0, 1'b1);
               end else if (n == 0) begin
                  add_result(1'b0, 0, '0, 1'b1);
               end else begin
                  p = rd_ptr;
                  for (int i = 0; i < n; i++) begin
                     burst.push_back(store[p]);
                     p = (p + 1) % FIFO_DEPTH;
                  end
                  if (rq.action == bfb_pkg::ACT_READ) begin
                     rd_ptr = p;
                     fill -= n;
                  end
                  for (int i = 0; i < n; i++)
                     add_result(1'b0, n, burst[i], i == n - 1);
               end
            end
         endcase
      endfunction

      function void compare_field(string name, logic [bfb_pkg::COUNT_W-1:0] exp_val,
                                  logic [bfb_pkg::COUNT_W-1:0] act_val);
         if (exp_val !== act_val) begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            errors++;
         end
      endfunction

      function void check_result(fifo_result_type got);
         fifo_result_type e;
         checked++;
         if (due_results.size() == 0) begin
            $error("result item with no request outstanding");
            errors++;
            return;
         end
         e = due_results.pop_front();
         compare_field("status", bfb_pkg::COUNT_W'(e.status),
                       bfb_pkg::COUNT_W'(got.status));
         compare_field("moved", bfb_pkg::COUNT_W'(e.moved),
                       bfb_pkg::COUNT_W'(got.moved));
         compare_field("read_byte", bfb_pkg::COUNT_W'(e.read_byte),
                       bfb_pkg::COUNT_W'(got.read_byte));
         compare_field("used_count", e.used_count, got.used_count);
         compare_field("free_count", e.free_count, got.free_count);
         compare_field("last", bfb_pkg::COUNT_W'(e.last),
                       bfb_pkg::COUNT_W'(got.last));
      endfunction
   endclass

   logic clock;
   logic reset;

   bfb_req_if req_chan ();
   bfb_rsp_if rsp_chan ();

   fifo_mirror mirror = new();

   byte_fifo_burst i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // build a request with given action and length, lanes at a fixed value
   function automatic fifo_request_type make_request(bfb_pkg::action_type act,
                                                     int unsigned len,
                                                     bfb_pkg::byte_type fill_byte);
      fifo_request_type rq;
      rq.action = act;
      rq.length = len[bfb_pkg::LEN_W-1:0];
      for (int i = 0; i < bfb_pkg::LANE_MAX; i++)
         rq.lane[i] = fill_byte;
      return rq;
   endfunction

   // random request, biased by phase: long filling stretches, then draining
   function automatic fifo_request_type random_request(int idx);
      fifo_request_type rq;
      int unsigned      r;
      int unsigned      len;
      int unsigned      room;
      r = $urandom_range(0, 99);
      room = FIFO_DEPTH - mirror.fill;
      if (idx % 100 < 75) begin
         if (r < 82) begin
            rq.action = bfb_pkg::ACT_WRITE;
            len = (room < bfb_pkg::LANE_MAX) ? $urandom_range(1, bfb_pkg::LANE_MAX)
                                             : $urandom_range(3, bfb_pkg::LANE_MAX);
         end else if (r < 92) begin
            rq.action = ($urandom_range(0, 1) != 0) ? bfb_pkg::ACT_READ
                                                    : bfb_pkg::ACT_PEEK;
            len = $urandom_range(1, 4);
         end else begin
            rq.action = bfb_pkg::ACT_WRITE;
            len = $urandom_range(0, 127);
         end
      end else begin
         if (r < 85) begin
            rq.action = (r < 60) ? bfb_pkg::ACT_READ : bfb_pkg::ACT_PEEK;
            if ($urandom_range(0, 99) < 20)
               len = BURST_MAX;
            else if (mirror.fill > 0 && $urandom_range(0, 99) < 70)
               len = $urandom_range(1, (mirror.fill < BURST_MAX) ? mirror.fill : BURST_MAX);
            else
               len = $urandom_range(1, BURST_MAX);
         end else if (r < 92) begin
            rq.action = bfb_pkg::ACT_WRITE;
            len = $urandom_range(0, bfb_pkg::LANE_MAX);
         end else if (r < 96) begin
            rq.action = bfb_pkg::ACT_CLEAR;
            len = $urandom_range(0, 127);
         end else begin
            rq.action = bfb_pkg::action_type'($urandom_range(0, 3));
            len = $urandom_range(0, 127);
         end
      end
      rq.length = len[bfb_pkg::LEN_W-1:0];
      for (int i = 0; i < bfb_pkg::LANE_MAX; i++)
         rq.lane[i] = bfb_pkg::BYTE_W'($urandom_range(0, 255));
      return rq;
   endfunction

   // offer one item, with an optional random gap first, and wait for it to be taken
   task automatic send_request(fifo_request_type rq, bit may_idle);
      if (may_idle && $urandom_range(0, 99) < 14) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.action <= rq.action;
      req_chan.length <= rq.length;
      req_chan.byte_0 <= rq.lane[0];
      req_chan.byte_1 <= rq.lane[1];
      req_chan.byte_2 <= rq.lane[2];
      req_chan.byte_3 <= rq.lane[3];
      req_chan.byte_4 <= rq.lane[4];
      req_chan.byte_5 <= rq.lane[5];
      req_chan.byte_6 <= rq.lane[6];
      req_chan.byte_7 <= rq.lane[7];
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      mirror.take_request(rq);
   endtask

   // directed items: empty fifo corner cases, length limits, data extremes
   task automatic run_directed();
      fifo_request_type rq;
      send_request(make_request(bfb_pkg::ACT_READ, 0, 8'h00), 1'b1);
      send_request(make_request(bfb_pkg::ACT_PEEK, 0, 8'h00), 1'b1);
      send_request(make_request(bfb_pkg::ACT_WRITE, 0, 8'hff), 1'b1);
      send_request(make_request(bfb_pkg::ACT_READ, 1, 8'h00), 1'b1);
      send_request(make_request(bfb_pkg::ACT_PEEK, 1, 8'h00), 1'b1);
      send_request(make_request(bfb_pkg::ACT_WRITE, 9, 8'h3c), 1'b1);
      send_request(make_request(bfb_pkg::ACT_WRITE, 127, 8'hff), 1'b1);
      send_request(make_request(bfb_pkg::ACT_WRITE, 8, 8'h00), 1'b1);
      send_request(make_request(bfb_pkg::ACT_WRITE, 8, 8'hff), 1'b1);
      send_request(make_request(bfb_pkg::ACT_WRITE, 1, 8'ha5), 1'b1);
      send_request(make_request(bfb_pkg::ACT_PEEK, 17, 8'h00), 1'b1);
      send_request(make_request(bfb_pkg::ACT_READ, 3, 8'h00), 1'b1);
      send_request(make_request(bfb_pkg::ACT_PEEK, 64, 8'h00), 1'b1);
      send_request(make_request(bfb_pkg::ACT_READ, 65, 8'h00), 1'b1);
      send_request(make_request(bfb_pkg::ACT_READ, 127, 8'h00), 1'b1);
      send_request(make_request(bfb_pkg::ACT_READ, 14, 8'h00), 1'b1);
      rq = make_request(bfb_pkg::ACT_WRITE, 8, 8'h00);
      for (int i = 0; i < bfb_pkg::LANE_MAX; i++)
         rq.lane[i] = 8'h01 << i;
      send_request(rq, 1'b1);
      send_request(make_request(bfb_pkg::ACT_CLEAR, 0, 8'h00), 1'b1);
      send_request(make_request(bfb_pkg::ACT_READ, 1, 8'h00), 1'b1);
      rq = make_request(bfb_pkg::ACT_WRITE, 8, 8'h00);
      for (int i = 0; i < bfb_pkg::LANE_MAX; i++)
         rq.lane[i] = ~(8'h01 << i);
      send_request(rq, 1'b1);
      send_request(make_request(bfb_pkg::ACT_PEEK, 8, 8'h00), 1'b1);
      send_request(make_request(bfb_pkg::ACT_CLEAR, 127, 8'h00), 1'b1);
   endtask

   // stimulus and end of run
   initial begin
      reset           <= 1'b1;
      req_chan.valid  <= 1'b0;
      req_chan.action <= bfb_pkg::ACT_WRITE;
      req_chan.length <= '0;
      req_chan.byte_0 <= '0;
      req_chan.byte_1 <= '0;
      req_chan.byte_2 <= '0;
      req_chan.byte_3 <= '0;
      req_chan.byte_4 <= '0;
      req_chan.byte_5 <= '0;
      req_chan.byte_6 <= '0;
      req_chan.byte_7 <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      // no gaps from the sender in one stretch of the random part
      for (int idx = 0; idx < RANDOM_ITEMS; idx++)
         send_request(random_request(idx), !(idx >= 30 && idx < 60));
      req_chan.valid <= 1'b0;
      while (mirror.due_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mirror.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // result side: random stalls, one long hold-off, and a stretch with no stalls
   initial begin
      int unsigned     hold_left;
      bit              held_off;
      bit              stall;
      fifo_result_type got;
      hold_left = 0;
      held_off = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            got.status     = rsp_chan.status;
            got.moved      = rsp_chan.moved;
            got.read_byte  = rsp_chan.read_byte;
            got.used_count = rsp_chan.used_count;
            got.free_count = rsp_chan.free_count;
            got.last       = rsp_chan.last;
            mirror.check_result(got);
         end
         if (!held_off && mirror.checked >= 100) begin
            held_off = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            stall = !(mirror.checked >= 300 && mirror.checked < 700)
                    && $urandom_range(0, 99) < 14;
            rsp_chan.ready <= !stall;
         end
      end
   end

   // watchdog on cycles with no item moving on either channel
   initial begin
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid === 1'b1 && req_chan.ready === 1'b1)
             || (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $error("no item moved for %0d cycles", IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
